// ===== src/touch_report_parser_calibrate_macros.svh =====
// ----------------------------------------------------------------------------
// Touch report parser assertion macros
// Shorthand for clocked implication checks, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef TOUCH_REPORT_PARSER_CALIBRATE_MACROS_SVH
`define TOUCH_REPORT_PARSER_CALIBRATE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define TRPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define TRPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tprc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprc_pkg
// Shared constants, event codes and controller/datapath interface structs
// ----------------------------------------------------------------------------
package tprc_pkg;

  localparam int BYTE_W     = 8;
  localparam int RAW_W      = 16;
  localparam int SIZE_W     = 12;
  localparam int PROD_W     = RAW_W + SIZE_W;
  localparam int XS_W       = 11;
  localparam int VALUE_W    = 12;
  localparam int EV_W       = 3;
  localparam int LIMIT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd4;

  localparam logic [RAW_W-1:0]   X_MIN_RESET = 16'd150;
  localparam logic [RAW_W-1:0]   X_MAX_RESET = 16'd3946;
  localparam logic [RAW_W-1:0]   Y_MIN_RESET = 16'd130;
  localparam logic [RAW_W-1:0]   Y_MAX_RESET = 16'd3966;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd2;

  // report kinds held by the parser
  localparam logic [1:0] RK_SKIP   = 2'd0;
  localparam logic [1:0] RK_SINGLE = 2'd1;
  localparam logic [1:0] RK_MULTI  = 2'd2;

  // first byte of a report
  localparam logic [BYTE_W-1:0] TYPE_SINGLE = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_MULTI  = 8'h02;

  // event codes
  localparam logic [EV_W-1:0] EV_X     = 3'd0;
  localparam logic [EV_W-1:0] EV_Y     = 3'd1;
  localparam logic [EV_W-1:0] EV_TOUCH = 3'd2;
  localparam logic [EV_W-1:0] EV_SLOT  = 3'd3;
  localparam logic [EV_W-1:0] EV_TRACK = 3'd4;
  localparam logic [EV_W-1:0] EV_MTX   = 3'd5;
  localparam logic [EV_W-1:0] EV_MTY   = 3'd6;
  localparam logic [EV_W-1:0] EV_SYNC  = 3'd7;

  localparam logic [VALUE_W-1:0] TRACK_RELEASE = '1;

  typedef struct packed {
    logic              load_in;
    logic              store_low;
    logic              store_label;
    logic              store_tip;
    logic              store_expected;
    logic              scale_start;
    logic              scale_y;
    logic              emit;
    logic [EV_W-1:0]   emit_kind;
    logic              emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  byte_val;
    logic               last;
    logic               tip;
    logic [LIMIT_W-1:0] limit_eff;
    logic [BYTE_W-1:0]  expected;
    logic               scale_done;
    logic               out_busy;
  } dp_status_t;

endpackage

// ===== src/tprc_scaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprc_scaler
// Clamp, multiply by screen size and restoring divide by the window span
// ----------------------------------------------------------------------------
module tprc_scaler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tprc_pkg::RAW_W-1:0]    raw,
  input  logic [tprc_pkg::RAW_W-1:0]    lo,
  input  logic [tprc_pkg::RAW_W-1:0]    hi,
  input  logic [tprc_pkg::SIZE_W-1:0]   size,
  output logic                          done,
  output logic [tprc_pkg::SIZE_W-1:0]   quotient
);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_DIV  = 2'd2;
  localparam int         CNT_W  = $clog2(tprc_pkg::SIZE_W);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(tprc_pkg::SIZE_W - 1);

  logic [1:0]                    phase;
  logic [CNT_W-1:0]              cnt;
  logic                          zero_span;
  logic [tprc_pkg::RAW_W-1:0]    diff;
  logic [tprc_pkg::RAW_W-1:0]    span;
  logic [tprc_pkg::SIZE_W-1:0]   size_q;
  logic [tprc_pkg::RAW_W-1:0]    rem;
  logic [tprc_pkg::SIZE_W-1:0]   qn;
  logic [tprc_pkg::RAW_W-1:0]    raw_clamped;
  logic [tprc_pkg::PROD_W-1:0]   prod;
  logic [tprc_pkg::RAW_W:0]      trial;
  logic                          trial_ge;

  always_comb begin
    if (raw < lo) begin
      raw_clamped = lo;
    end else if (raw > hi) begin
      raw_clamped = hi;
    end else begin
      raw_clamped = raw;
    end
  end

  assign prod     = tprc_pkg::PROD_W'(diff) * tprc_pkg::PROD_W'(size_q);
  assign trial    = {rem, qn[tprc_pkg::SIZE_W-1]};
  assign trial_ge = trial >= {1'b0, span};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (phase == P_DIV) && (cnt == DIV_LAST);
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            phase <= P_MUL;
          end
        end
        P_MUL: begin
          phase <= P_DIV;
          cnt   <= '0;
        end
        P_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            phase <= P_IDLE;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && (phase == P_IDLE)) begin
      zero_span <= hi <= lo;
      diff      <= raw_clamped - lo;
      span      <= hi - lo;
      size_q    <= size;
    end
    if (phase == P_MUL) begin
      // the quotient never exceeds size, so the top part is already below span
      rem <= prod[tprc_pkg::PROD_W-1:tprc_pkg::SIZE_W];
      qn  <= prod[tprc_pkg::SIZE_W-1:0];
    end else if (phase == P_DIV) begin
      rem <= trial_ge ? tprc_pkg::RAW_W'(trial - {1'b0, span})
                      : trial[tprc_pkg::RAW_W-1:0];
      qn  <= {qn[tprc_pkg::SIZE_W-2:0], trial_ge};
    end
  end

  assign quotient = zero_span ? '0 : qn;

endmodule

// ===== src/tprc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprc_datapath
// Calibration registers, report field holds, scaler and event output register
// ----------------------------------------------------------------------------
module tprc_datapath #(
  parameter int SCREEN_WIDTH  = 1920,
  parameter int SCREEN_HEIGHT = 1080,
  parameter int MAX_TOUCHES   = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tprc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tprc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [tprc_pkg::BYTE_W-1:0]       report_byte,
  input  logic                              report_last,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [tprc_pkg::EV_W-1:0]         out_kind,
  output logic [tprc_pkg::VALUE_W-1:0]      out_value,
  output logic                              out_last,
  input  tprc_pkg::dp_cmd_t                 cmd,
  output tprc_pkg::dp_status_t              status
);

  logic [tprc_pkg::RAW_W-1:0]   x_min;
  logic [tprc_pkg::RAW_W-1:0]   x_max;
  logic [tprc_pkg::RAW_W-1:0]   y_min;
  logic [tprc_pkg::RAW_W-1:0]   y_max;
  logic [tprc_pkg::LIMIT_W-1:0] touch_limit;

  logic [tprc_pkg::BYTE_W-1:0]  byte_reg;
  logic                         last_reg;
  logic [tprc_pkg::BYTE_W-1:0]  low_byte_hold;
  logic [tprc_pkg::BYTE_W-1:0]  contact_label;
  logic                         tip_held;
  logic [tprc_pkg::BYTE_W-1:0]  contacts_expected;
  logic [tprc_pkg::XS_W-1:0]    x_scaled_hold;
  logic [tprc_pkg::SIZE_W-1:0]  y_scaled_hold;
  logic                         scale_y_q;

  logic                         scale_done;
  logic [tprc_pkg::SIZE_W-1:0]  scale_q;
  logic [tprc_pkg::VALUE_W-1:0] emit_value;

  localparam logic [tprc_pkg::LIMIT_W-1:0] MAX_LIMIT = tprc_pkg::LIMIT_W'(MAX_TOUCHES);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min       <= tprc_pkg::X_MIN_RESET;
      x_max       <= tprc_pkg::X_MAX_RESET;
      y_min       <= tprc_pkg::Y_MIN_RESET;
      y_max       <= tprc_pkg::Y_MAX_RESET;
      touch_limit <= tprc_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tprc_pkg::REG_X_MIN: x_min       <= cfg_data;
        tprc_pkg::REG_X_MAX: x_max       <= cfg_data;
        tprc_pkg::REG_Y_MIN: y_min       <= cfg_data;
        tprc_pkg::REG_Y_MAX: y_max       <= cfg_data;
        tprc_pkg::REG_LIMIT: touch_limit <= cfg_data[tprc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  tprc_scaler u_scaler (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.scale_start),
    .raw      ({byte_reg, low_byte_hold}),
    .lo       (cmd.scale_y ? y_min : x_min),
    .hi       (cmd.scale_y ? y_max : x_max),
    .size     (cmd.scale_y ? tprc_pkg::SIZE_W'(SCREEN_HEIGHT)
                           : tprc_pkg::SIZE_W'(SCREEN_WIDTH)),
    .done     (scale_done),
    .quotient (scale_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      low_byte_hold     <= '0;
      contact_label     <= '0;
      tip_held          <= 1'b0;
      contacts_expected <= '0;
      x_scaled_hold     <= '0;
    end else begin
      if (cmd.store_low)      low_byte_hold     <= byte_reg;
      if (cmd.store_label)    contact_label     <= byte_reg;
      if (cmd.store_tip)      tip_held          <= byte_reg[0];
      if (cmd.store_expected) contacts_expected <= byte_reg;
      if (scale_done && !scale_y_q) begin
        x_scaled_hold <= scale_q[tprc_pkg::XS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      byte_reg <= report_byte;
      last_reg <= report_last;
    end
    if (cmd.scale_start) begin
      scale_y_q <= cmd.scale_y;
    end
    if (scale_done && scale_y_q) begin
      y_scaled_hold <= scale_q;
    end
  end

  always_comb begin
    unique case (cmd.emit_kind) inside
      tprc_pkg::EV_X, tprc_pkg::EV_MTX: emit_value = {1'b0, x_scaled_hold};
      tprc_pkg::EV_Y, tprc_pkg::EV_MTY: emit_value = y_scaled_hold;
      tprc_pkg::EV_TOUCH: emit_value = tprc_pkg::VALUE_W'(byte_reg[0]);
      tprc_pkg::EV_SLOT:  emit_value = tprc_pkg::VALUE_W'(contact_label);
      tprc_pkg::EV_TRACK: emit_value = tip_held ? tprc_pkg::VALUE_W'(contact_label)
                                                : tprc_pkg::TRACK_RELEASE;
      default:            emit_value = '0;
    endcase
  end

  // output register: one transfer waits here while the parser moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind  <= cmd.emit_kind;
      out_value <= emit_value;
      out_last  <= cmd.emit_last;
    end
  end

  always_comb begin
    status.byte_val   = byte_reg;
    status.last       = last_reg;
    status.tip        = tip_held;
    status.limit_eff  = (touch_limit > MAX_LIMIT) ? MAX_LIMIT : touch_limit;
    status.expected   = contacts_expected;
    status.scale_done = scale_done;
    status.out_busy   = out_valid && out_stall;
  end

endmodule

// ===== src/tprc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprc_ctrl
// Report parser state machine: byte position, contact tracking, event plan
// ----------------------------------------------------------------------------
module tprc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output tprc_pkg::dp_cmd_t     cmd,
  input  tprc_pkg::dp_status_t  status
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_SCALE  = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  localparam int POS_W      = 6;
  localparam int CN_W       = 4;
  localparam int OFF_W      = 3;
  localparam int PLAN_DEPTH = 5;
  localparam int PLAN_W     = $clog2(PLAN_DEPTH);

  localparam logic [POS_W-1:0] POS_KIND  = 6'd0;
  localparam logic [POS_W-1:0] POS_COUNT = 6'd1;
  localparam logic [POS_W-1:0] POS_X_LO  = 6'd1;
  localparam logic [POS_W-1:0] POS_X_HI  = 6'd2;
  localparam logic [POS_W-1:0] POS_Y_LO  = 6'd3;
  localparam logic [POS_W-1:0] POS_Y_HI  = 6'd4;
  localparam logic [POS_W-1:0] POS_TIP   = 6'd5;
  localparam logic [POS_W-1:0] POS_SAT   = '1;

  localparam logic [OFF_W-1:0] OFF_LABEL = 3'd0;
  localparam logic [OFF_W-1:0] OFF_TIP   = 3'd1;
  localparam logic [OFF_W-1:0] OFF_X_LO  = 3'd2;
  localparam logic [OFF_W-1:0] OFF_X_HI  = 3'd3;
  localparam logic [OFF_W-1:0] OFF_Y_LO  = 3'd4;
  localparam logic [OFF_W-1:0] OFF_Y_HI  = 3'd5;

  logic [1:0]        state;
  logic [POS_W-1:0]  byte_position;
  logic [POS_W-1:0]  byte_position_next;
  logic [1:0]        report_kind;
  logic [1:0]        report_kind_next;
  logic [CN_W-1:0]   contact_number;
  logic [CN_W-1:0]   contact_number_next;
  logic [OFF_W-1:0]  contact_offset;
  logic [OFF_W-1:0]  contact_offset_next;

  logic [tprc_pkg::EV_W-1:0] plan [PLAN_DEPTH];
  logic [PLAN_W-1:0]         plan_cnt;
  logic [PLAN_W-1:0]         plan_idx;

  logic [tprc_pkg::EV_W-1:0] ev_list [PLAN_DEPTH];
  logic [PLAN_W-1:0]         ev_cnt;
  logic                      d_store_low;
  logic                      d_store_label;
  logic                      d_store_tip;
  logic                      d_store_expected;
  logic                      d_scale_start;
  logic                      d_scale_y;
  logic [CN_W-1:0]           target_byte;
  logic [CN_W-1:0]           target_held;
  logic                      emit_ok;

  // contacts to take: min(count, limit)
  assign target_byte = (status.byte_val < tprc_pkg::BYTE_W'(status.limit_eff))
                       ? status.byte_val[CN_W-1:0] : status.limit_eff;
  assign target_held = (status.expected < tprc_pkg::BYTE_W'(status.limit_eff))
                       ? status.expected[CN_W-1:0] : status.limit_eff;

  always_comb begin
    byte_position_next  = byte_position;
    report_kind_next    = report_kind;
    contact_number_next = contact_number;
    contact_offset_next = contact_offset;
    for (int i = 0; i < PLAN_DEPTH; i++) begin
      ev_list[i] = tprc_pkg::EV_SYNC;
    end
    ev_cnt           = '0;
    d_store_low      = 1'b0;
    d_store_label    = 1'b0;
    d_store_tip      = 1'b0;
    d_store_expected = 1'b0;
    d_scale_start    = 1'b0;
    d_scale_y        = 1'b0;

    if (byte_position == POS_KIND) begin
      if (status.byte_val == tprc_pkg::TYPE_SINGLE) begin
        report_kind_next = tprc_pkg::RK_SINGLE;
      end else if (status.byte_val == tprc_pkg::TYPE_MULTI) begin
        report_kind_next = tprc_pkg::RK_MULTI;
      end else begin
        report_kind_next = tprc_pkg::RK_SKIP;
      end
      contact_number_next = '0;
      contact_offset_next = '0;
    end else if (report_kind == tprc_pkg::RK_SINGLE) begin
      if (byte_position == POS_X_LO || byte_position == POS_Y_LO) begin
        d_store_low = 1'b1;
      end else if (byte_position == POS_X_HI) begin
        d_scale_start = 1'b1;
      end else if (byte_position == POS_Y_HI) begin
        d_scale_start = 1'b1;
        d_scale_y     = 1'b1;
        ev_list[0]    = tprc_pkg::EV_X;
        ev_list[1]    = tprc_pkg::EV_Y;
        ev_cnt        = PLAN_W'(2);
      end else if (byte_position == POS_TIP) begin
        ev_list[0]       = tprc_pkg::EV_TOUCH;
        ev_list[1]       = tprc_pkg::EV_SYNC;
        ev_cnt           = PLAN_W'(2);
        report_kind_next = tprc_pkg::RK_SKIP;
      end
    end else if (report_kind == tprc_pkg::RK_MULTI) begin
      if (byte_position == POS_COUNT) begin
        d_store_expected    = 1'b1;
        contact_offset_next = '0;
        if (target_byte == '0) begin
          ev_list[0]       = tprc_pkg::EV_SYNC;
          ev_cnt           = PLAN_W'(1);
          report_kind_next = tprc_pkg::RK_SKIP;
        end
      end else begin
        contact_offset_next = (contact_offset == OFF_Y_HI) ? '0 : contact_offset + 1'b1;
        unique case (contact_offset) inside
          OFF_LABEL: d_store_label = 1'b1;
          OFF_TIP:   d_store_tip   = 1'b1;
          OFF_X_LO, OFF_Y_LO: d_store_low = 1'b1;
          OFF_X_HI:  d_scale_start = 1'b1;
          OFF_Y_HI: begin
            d_scale_start = 1'b1;
            d_scale_y     = 1'b1;
            ev_list[0]    = tprc_pkg::EV_SLOT;
            ev_list[1]    = tprc_pkg::EV_TRACK;
            ev_cnt        = PLAN_W'(2);
            if (status.tip) begin
              ev_list[2] = tprc_pkg::EV_MTX;
              ev_list[3] = tprc_pkg::EV_MTY;
              ev_cnt     = PLAN_W'(4);
            end
            contact_number_next = contact_number + 1'b1;
            if (contact_number_next >= target_held) begin
              ev_list[ev_cnt]  = tprc_pkg::EV_SYNC;
              ev_cnt           = ev_cnt + 1'b1;
              report_kind_next = tprc_pkg::RK_SKIP;
            end
          end
          default: ;
        endcase
      end
    end

    // end of report: a multitouch report still open closes with a sync
    if (status.last) begin
      if (report_kind_next == tprc_pkg::RK_MULTI) begin
        ev_list[ev_cnt] = tprc_pkg::EV_SYNC;
        ev_cnt          = ev_cnt + 1'b1;
      end
      byte_position_next  = '0;
      report_kind_next    = tprc_pkg::RK_SKIP;
      contact_number_next = '0;
      contact_offset_next = '0;
    end else if (byte_position != POS_SAT) begin
      byte_position_next = byte_position + 1'b1;
    end
  end

  assign emit_ok  = (state == S_EMIT) && !status.out_busy;
  assign in_stall = rst || (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      byte_position  <= '0;
      report_kind    <= tprc_pkg::RK_SKIP;
      contact_number <= '0;
      contact_offset <= '0;
      plan_cnt       <= '0;
      plan_idx       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          byte_position  <= byte_position_next;
          report_kind    <= report_kind_next;
          contact_number <= contact_number_next;
          contact_offset <= contact_offset_next;
          plan_cnt       <= ev_cnt;
          plan_idx       <= '0;
          if (d_scale_start) begin
            state <= S_SCALE;
          end else if (ev_cnt != '0) begin
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCALE: begin
          if (status.scale_done) begin
            state <= (plan_cnt != '0) ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            plan_idx <= plan_idx + 1'b1;
            if (plan_idx == plan_cnt - 1'b1) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DECODE) begin
      for (int i = 0; i < PLAN_DEPTH; i++) begin
        plan[i] <= ev_list[i];
      end
    end
  end

  always_comb begin
    cmd.load_in        = (state == S_IDLE) && in_valid;
    cmd.store_low      = (state == S_DECODE) && d_store_low;
    cmd.store_label    = (state == S_DECODE) && d_store_label;
    cmd.store_tip      = (state == S_DECODE) && d_store_tip;
    cmd.store_expected = (state == S_DECODE) && d_store_expected;
    cmd.scale_start    = (state == S_DECODE) && d_scale_start;
    cmd.scale_y        = d_scale_y;
    cmd.emit           = emit_ok;
    cmd.emit_kind      = plan[plan_idx];
    cmd.emit_last      = (plan_idx == plan_cnt - 1'b1);
  end

endmodule

// ===== src/touch_report_parser_calibrate.sv =====
`timescale 1ns / 1ps
// A byte with no arithmetic passes through IDLE and DECODE; a coordinate high byte also
//   runs clamp, 16x12 multiply and a 12-step restoring divide in the shared scaler.
// The parser takes one byte at a time and stalls input until its events are emitted.
// The output register holds a pending event while the next byte is taken.
// Reset: synchronous rst clears the parser and output valid and restores the
//   calibration registers to their defaults.
// ----------------------------------------------------------------------------
// touch_report_parser_calibrate
// Touch report parser with calibration window scaling to screen coordinates
// ----------------------------------------------------------------------------
module touch_report_parser_calibrate #(
  parameter int SCREEN_WIDTH  = 1920,
  parameter int SCREEN_HEIGHT = 1080,
  parameter int MAX_TOUCHES   = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [tprc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tprc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            report_byte,
  input  logic                                  report_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [2:0]                            event_kind,
  output logic signed [11:0]                    event_value,
  output logic                                  run_last
);

  tprc_pkg::dp_cmd_t    cmd;
  tprc_pkg::dp_status_t status;
  logic [tprc_pkg::VALUE_W-1:0] value_raw;

  tprc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  tprc_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MAX_TOUCHES   (MAX_TOUCHES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .report_byte (report_byte),
    .report_last (report_last),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_kind    (event_kind),
    .out_value   (value_raw),
    .out_last    (run_last),
    .cmd         (cmd),
    .status      (status)
  );

  assign event_value = $signed(value_raw);

endmodule

// ===== src/tprc_checker.sv =====
`timescale 1ns / 1ps
`include "touch_report_parser_calibrate_macros.svh"
// ----------------------------------------------------------------------------
// tprc_checker
// Port-level checks on event ordering and handshake, bound to the top level
// ----------------------------------------------------------------------------
module tprc_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic [2:0]                            event_kind,
  input logic signed [11:0]                    event_value,
  input logic                                  run_last
);

  `TRPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(event_kind) && $stable(event_value) && $stable(run_last),
    "stalled event changed")

  // one byte at a time: a transfer in closes the input until it is parsed
  `TRPC_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall,
    "input taken again right after a transfer")

  // sync always closes the run of events for its byte
  `TRPC_ASSERT_SAME(a_sync_last, out_valid && event_kind == tprc_pkg::EV_SYNC,
    run_last && event_value == 12'sd0, "sync not last or nonzero")

  // x is always followed by y, slot by tracking id
  `TRPC_ASSERT_SAME(a_no_early_end,
    out_valid && (event_kind == tprc_pkg::EV_X || event_kind == tprc_pkg::EV_SLOT),
    !run_last, "run ended on x or slot")

endmodule

bind touch_report_parser_calibrate tprc_checker u_checker (.*);
